// ----- rtl/efr_pkg.sv -----
// Package for the escaped frame receiver: shared types, codes and constants.
// Also holds the byte-wide CRC-16/ARC update. No dependencies.
package efr_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;
    localparam int MIN_FRAME     = 3;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] ESC_RESET  = 8'd241;
    localparam logic [7:0] TERM_RESET = 8'd242;

    localparam logic [1:0] ST_SHORT = 2'd0;
    localparam logic [1:0] ST_GOOD  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic REG_ESCAPE = 1'b0;
    localparam logic REG_TERM   = 1'b1;

    // classified word handed from the front to the back
    typedef struct packed {
        logic       term;
        logic [7:0] data;
    } t_token;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/efr_front.sv -----
// Front end: accepts raw bytes, strips escapes, tags terminators.
// Depends on efr_pkg.
module efr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_escape_code,
    input  logic [7:0]     i_terminator_code,
    output logic           o_push,
    output efr_pkg::t_token o_token,
    input  logic           i_queue_ready
);

    logic r_esc_pend;
    logic n_esc_pend;
    logic w_accept;

    assign o_ready  = i_queue_ready;
    assign w_accept = i_valid && i_queue_ready;

    always_comb begin
        n_esc_pend    = r_esc_pend;
        o_push        = 1'b0;
        o_token.term  = 1'b0;
        o_token.data  = i_rx_byte;
        if (w_accept) begin
            if (r_esc_pend) begin
                n_esc_pend = 1'b0;
                o_push     = 1'b1;
            end else if (i_rx_byte == i_escape_code) begin
                n_esc_pend = 1'b1;
            end else begin
                o_push       = 1'b1;
                o_token.term = (i_rx_byte == i_terminator_code);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pend <= 1'b0;
        end else begin
            r_esc_pend <= n_esc_pend;
        end
    end

endmodule

// ----- rtl/efr_queue.sv -----
// Short word queue between front and back.
// Depends on efr_pkg.
module efr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  efr_pkg::t_token i_token,
    output logic            o_ready,
    output logic            o_valid,
    output efr_pkg::t_token o_token,
    input  logic            i_pop
);

    localparam int DEPTH = efr_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    efr_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_count != (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/efr_back.sv -----
// Back end: stores bytes, runs CRC-16/ARC through a two-byte delay line,
// and builds the frame result at a terminator. Depends on efr_pkg.
module efr_back #(
    parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  efr_pkg::t_token i_token,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_frame_status,
    output logic [8:0]      o_frame_length,
    output logic [7:0]      o_command_code,
    output logic [15:0]     o_computed_crc,
    output logic [15:0]     o_received_crc
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);
    localparam logic [CW-1:0] MIN_C = CW'(efr_pkg::MIN_FRAME);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [7:0]    r_held0;
    logic [7:0]    r_held1;
    logic [7:0]    r_first;
    logic          r_ovalid;
    logic [1:0]    r_status;
    logic [8:0]    r_len;
    logic [7:0]    r_cmd;
    logic [15:0]   r_comp;
    logic [15:0]   r_recv;

    logic          w_slot_free;
    logic          w_store;
    logic          w_term;
    logic          w_short;
    logic [15:0]   w_recv;
    logic [CW+8:0] w_len_ext;

    assign w_slot_free = !r_ovalid || i_ready;
    assign o_pop       = i_tok_valid && (!i_token.term || w_slot_free);
    assign w_store     = o_pop && !i_token.term && (r_count < MAX_C);
    assign w_term      = o_pop && i_token.term;
    assign w_short     = (r_count < MIN_C);
    assign w_recv      = {r_held1, r_held0};
    assign w_len_ext   = {9'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_first <= '0;
        end else if (w_term) begin
            r_count <= '0;
            r_crc   <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_first <= '0;
        end else if (w_store) begin
            if (r_count == '0) begin
                r_first <= i_token.data;
            end
            if (r_count >= TWO_C) begin
                r_crc <= efr_pkg::crc_byte(r_crc, r_held0);
            end
            r_held0 <= r_held1;
            r_held1 <= i_token.data;
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_term) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_term) begin
            r_len <= w_len_ext[8:0];
            r_cmd <= r_first;
            if (w_short) begin
                r_status <= efr_pkg::ST_SHORT;
                r_comp   <= '0;
                r_recv   <= '0;
            end else begin
                r_status <= (r_crc == w_recv) ? efr_pkg::ST_GOOD : efr_pkg::ST_BAD;
                r_comp   <= r_crc;
                r_recv   <= w_recv;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_frame_status = r_status;
    assign o_frame_length = r_len;
    assign o_command_code = r_cmd;
    assign o_computed_crc = r_comp;
    assign o_received_crc = r_recv;

endmodule

// ----- rtl/escaped_frame_receiver_crc16.sv -----
// Escaped frame receiver with CRC-16/ARC check, top level.
// Takes one byte per cycle while the queue has room; a terminator's result is
// registered on leaving the queue, later while queued words or a result wait.
// Front classifies, queue decouples, back stores with a byte-wide CRC update.
// Reset (synchronous, active low) clears frame state, queue and result valid,
// and restores escape 241 and terminator 242. Depends on efr_pkg.
module escaped_frame_receiver_crc16 #(
    parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_frame_status,
    output logic [8:0]  o_frame_length,
    output logic [7:0]  o_command_code,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_received_crc,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]      r_escape_code;
    logic [7:0]      r_terminator_code;
    logic            w_cfg_wr;
    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop;
    efr_pkg::t_token w_front_tok;
    efr_pkg::t_token w_back_tok;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = {24'b0, (paddr[2] == efr_pkg::REG_TERM) ? r_terminator_code
                                                              : r_escape_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_code     <= efr_pkg::ESC_RESET;
            r_terminator_code <= efr_pkg::TERM_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == efr_pkg::REG_ESCAPE) begin
                r_escape_code <= pwdata[7:0];
            end else begin
                r_terminator_code <= pwdata[7:0];
            end
        end
    end

    efr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .i_escape_code     (r_escape_code),
        .i_terminator_code (r_terminator_code),
        .o_push            (w_push),
        .o_token           (w_front_tok),
        .i_queue_ready     (w_q_ready)
    );

    efr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_front_tok),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_token (w_back_tok),
        .i_pop   (w_pop)
    );

    efr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (w_q_valid),
        .i_token        (w_back_tok),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length),
        .o_command_code (o_command_code),
        .o_computed_crc (o_computed_crc),
        .o_received_crc (o_received_crc)
    );

endmodule

// ----- dv/testbench.sv -----
// Testbench for escaped_frame_receiver_crc16: sends escaped, terminated frames
// and checks every frame result against an in-bench predictor of the receiver.
// Depends on efr_pkg and the escaped_frame_receiver_crc16 RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_CAP = efr_pkg::MAX_FRAME_DEF;
    localparam int SETTLE    = 8;
    localparam int RX_HOLD   = 300;
    localparam logic [2:0] ADDR_ESCAPE = {efr_pkg::REG_ESCAPE, 2'b00};
    localparam logic [2:0] ADDR_TERM   = {efr_pkg::REG_TERM, 2'b00};

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        logic [1:0]  status;
        logic [8:0]  frame_len;
        logic [7:0]  command;
        logic [15:0] crc_calc;
        logic [15:0] crc_rx;
    } t_frame_result;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_frame_status;
    logic [8:0]  o_frame_length;
    logic [7:0]  o_command_code;
    logic [15:0] o_computed_crc;
    logic [15:0] o_received_crc;
    logic [31:0] prdata;
    logic        pready;

    escaped_frame_receiver_crc16 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length),
        .o_command_code (o_command_code),
        .o_computed_crc (o_computed_crc),
        .o_received_crc (o_received_crc),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // predictor state and register copies
    logic        esc_armed;
    int unsigned held_count;
    logic [15:0] crc_acc;
    logic [7:0]  tail_bytes [2];
    logic [7:0]  lead_byte;
    logic [7:0]  cfg_escape;
    logic [7:0]  cfg_term;

    t_frame_result expected_frames[$];
    int          errors = 0;
    int unsigned bytes_sent = 0;
    bit          tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int unsigned stall_reqs = 0;
    int unsigned stall_served = 0;
    int unsigned stall_left = 0;

    function automatic logic [15:0] crc16_arc(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ efr_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void frame_clear();
        esc_armed     = 1'b0;
        held_count    = 0;
        crc_acc       = 16'h0000;
        tail_bytes[0] = 8'h00;
        tail_bytes[1] = 8'h00;
        lead_byte     = 8'h00;
    endfunction

    function automatic void frame_store(input logic [7:0] b);
        if (held_count < FRAME_CAP) begin
            if (held_count == 0) begin
                lead_byte = b;
            end
            if (held_count >= 2) begin
                crc_acc = crc16_arc(crc_acc, tail_bytes[0]);
            end
            tail_bytes[0] = tail_bytes[1];
            tail_bytes[1] = b;
            held_count++;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        t_frame_result r;
        if (esc_armed) begin
            esc_armed = 1'b0;
            frame_store(b);
        end else if (b == cfg_escape) begin
            esc_armed = 1'b1;
        end else if (b != cfg_term) begin
            frame_store(b);
        end else begin
            r.frame_len = 9'(held_count);
            r.command   = lead_byte;
            if (held_count < efr_pkg::MIN_FRAME) begin
                r.status   = efr_pkg::ST_SHORT;
                r.crc_calc = 16'h0000;
                r.crc_rx   = 16'h0000;
            end else begin
                r.crc_calc = crc_acc;
                r.crc_rx   = {tail_bytes[1], tail_bytes[0]};
                r.status   = (r.crc_calc == r.crc_rx) ? efr_pkg::ST_GOOD : efr_pkg::ST_BAD;
            end
            expected_frames.push_back(r);
            frame_clear();
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: random ready, requested hold-offs, checks
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_frames.size() == 0) begin
                $error("frame result with none expected: status %0d length %0d",
                       o_frame_status, o_frame_length);
                errors++;
            end else begin
                want = expected_frames.pop_front();
                check_field("frame_status", 16'(want.status), 16'(o_frame_status));
                check_field("frame_length", 16'(want.frame_len), 16'(o_frame_length));
                check_field("command_code", 16'(want.command), 16'(o_command_code));
                check_field("computed_crc", want.crc_calc, o_computed_crc);
                check_field("received_crc", want.crc_rx, o_received_crc);
            end
        end
        if (stall_reqs != stall_served) begin
            stall_served = stall_reqs;
            stall_left   = RX_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (rx_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 27);
        end
    end

    task automatic apply_reset();
        cfg_escape = efr_pkg::ESC_RESET;
        cfg_term   = efr_pkg::TERM_RESET;
        frame_clear();
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!tx_steady && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_literal(input logic [7:0] b);
        if (b == cfg_escape || b == cfg_term || $urandom_range(19) == 0) begin
            send_byte(cfg_escape);
        end
        send_byte(b);
    endtask

    // body and its checksum, without the terminator
    task automatic send_payload(input t_byte_q body, input bit corrupt);
        logic [15:0] crc;
        t_byte_q     stored;
        crc = 16'h0000;
        foreach (body[i]) crc = crc16_arc(crc, body[i]);
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        stored = body;
        stored.push_back(crc[7:0]);
        stored.push_back(crc[15:8]);
        foreach (stored[i]) send_literal(stored[i]);
    endtask

    task automatic send_frame(input t_byte_q body, input bit corrupt);
        send_payload(body, corrupt);
        send_byte(cfg_term);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return cfg_escape;
            1:       return cfg_term;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_byte_q random_body(input int n);
        t_byte_q q;
        for (int i = 0; i < n; i++) q.push_back(pick_byte());
        return q;
    endfunction

    function automatic t_byte_q plain_body(input int n);
        t_byte_q q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(1, 200)));
        return q;
    endfunction

    // stop offering words, wait for all results, let the pipeline empty
    task automatic drain_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_reg(input logic [2:0] addr, input logic [7:0] val, input string name);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd[7:0] !== val) begin
            $error("%s readback: expected 0x%0h, got 0x%0h", name, val, rd[7:0]);
            errors++;
        end
    endtask

    task automatic set_codes(input logic [7:0] esc, input logic [7:0] term);
        drain_input();
        write_reg(ADDR_ESCAPE, esc);
        cfg_escape = esc;
        write_reg(ADDR_TERM, term);
        cfg_term = term;
        verify_reg(ADDR_ESCAPE, esc, "escape_code");
        verify_reg(ADDR_TERM, term, "terminator_code");
    endtask

    task automatic test_short_frames();
        send_byte(cfg_term);
        send_byte(8'h00);
        send_byte(cfg_term);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(cfg_term);
    endtask

    task automatic test_crc_check();
        send_frame('{8'h00, 8'hFF}, 1'b0);
        send_frame('{8'hFF}, 1'b1);
        send_frame('{8'h01}, 1'b0);
    endtask

    task automatic test_escaped_codes();
        send_frame('{cfg_escape, cfg_term, cfg_escape}, 1'b0);
        send_byte(cfg_escape);
        send_byte(8'h5C);
        send_byte(cfg_escape);
        send_byte(cfg_term);
        send_byte(cfg_term);
    endtask

    // escape wins when both codes match; frame in progress survives the rewrite
    task automatic test_shared_code();
        set_codes(8'h5A, 8'h5A);
        send_byte(8'h5A);
        send_byte(8'h5A);
        send_byte(8'h01);
        send_byte(8'h5A);
        send_byte(8'h33);
        send_byte(8'hC3);
        set_codes(efr_pkg::ESC_RESET, efr_pkg::TERM_RESET);
        send_byte(cfg_term);
    endtask

    task automatic test_code_extremes();
        set_codes(8'h00, 8'hFF);
        send_frame('{8'h00, 8'hFF, 8'h7F}, 1'b0);
        send_byte(cfg_term);
        set_codes(8'hFF, 8'h00);
        send_frame('{8'hFF, 8'h00, 8'h80}, 1'b0);
        send_frame('{8'h00}, 1'b1);
        set_codes(efr_pkg::ESC_RESET, efr_pkg::TERM_RESET);
    endtask

    // frame fills the buffer exactly; later bytes, escaped ones too, are dropped
    task automatic test_full_buffer();
        send_payload(plain_body(FRAME_CAP - 2), 1'b0);
        send_literal(8'h5C);
        send_literal(8'hA7);
        send_byte(cfg_escape);
        send_byte(cfg_term);
        send_byte(cfg_term);
    endtask

    task automatic test_back_to_back();
        rx_steady <= 1'b1;
        tx_steady = 1'b1;
        for (int i = 0; i < 8; i++) send_frame(random_body($urandom_range(0, 8)), 1'b0);
        drain_input();
        rx_steady <= 1'b0;
        tx_steady = 1'b0;
    endtask

    // receiver holds off while frames keep coming, so the input backs up
    task automatic test_backpressure();
        stall_reqs <= stall_reqs + 1;
        tx_steady = 1'b1;
        for (int i = 0; i < 8; i++) send_frame(random_body($urandom_range(1, 4)), 1'b0);
        tx_steady = 1'b0;
        drain_input();
    endtask

    task automatic run_traffic(input int unsigned count);
        int unsigned start;
        int unsigned kind;
        t_byte_q     body;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                send_frame(random_body($urandom_range(0, 10)), 1'b0);
            end else if (kind < 80) begin
                send_frame(random_body($urandom_range(1, 10)), 1'b1);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 5)) send_byte(pick_byte());
            end else if (kind < 94) begin
                send_byte(cfg_term);
            end else begin
                // truncated frame, merges into the next one
                body = random_body($urandom_range(1, 6));
                foreach (body[i]) send_literal(body[i]);
            end
        end
        send_byte(cfg_term);
    endtask

    task automatic test_random_traffic();
        logic [7:0] esc;
        logic [7:0] term;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin esc = efr_pkg::ESC_RESET; term = efr_pkg::TERM_RESET; end
                1: begin esc = 8'h00;              term = 8'hFF;               end
                2: begin esc = 8'hFF;              term = 8'h00;               end
                default: begin
                    esc  = 8'($urandom);
                    term = 8'($urandom);
                    if (term == esc) begin
                        term = esc ^ 8'h01;
                    end
                end
            endcase
            set_codes(esc, term);
            run_traffic(36);
        end
    endtask

    initial begin
        apply_reset();
        test_short_frames();
        test_crc_check();
        test_escaped_codes();
        test_shared_code();
        test_code_extremes();
        test_full_buffer();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();
        drain_input();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
